@@ rtl/core/ctlog_pkg.sv @@
// Shared constants and types for the circular trace log.
`default_nettype none
package ctlog_pkg;

  localparam int Depth    = 256;
  localparam int AddrW    = $clog2(Depth);
  localparam int CapW     = AddrW + 1;
  localparam int RecW     = 64;
  localparam int CountW   = 32;
  localparam int StatusW  = 2;

  localparam logic [StatusW-1:0] StOk          = 2'd0;
  localparam logic [StatusW-1:0] StNotFound    = 2'd1;
  localparam logic [StatusW-1:0] StUnsupported = 2'd2;
  localparam logic [StatusW-1:0] StIntegrity   = 2'd3;

  localparam logic OpAppend = 1'b0;
  localparam logic OpRead   = 1'b1;

  localparam logic [CapW-1:0] CapReset = CapW'(Depth);

  // Request from the control unit for one transaction.
  typedef struct packed {
    logic                mem_we;
    logic                mem_re;
    logic [AddrW-1:0]    mem_addr;
    logic                read_ok;
    logic [StatusW-1:0]  status;
    logic [AddrW-1:0]    write_position;
    logic [CapW-1:0]     held_count;
  } ctlog_req_t;

endpackage
`default_nettype wire

@@ rtl/core/ctlog_ram.sv @@
// Record store: single-port-write, registered-read memory.
`default_nettype none
module ctlog_ram (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [ctlog_pkg::AddrW-1:0]   wr_addr,
  input  wire logic [ctlog_pkg::RecW-1:0]    wr_data,
  input  wire logic                          rd_en,
  input  wire logic [ctlog_pkg::AddrW-1:0]   rd_addr,
  output logic      [ctlog_pkg::RecW-1:0]    rd_data
);

  logic [ctlog_pkg::RecW-1:0] mem [ctlog_pkg::Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ctlog_ctrl.sv @@
// Ring control: capacity register, write position, saturating count, status decode.
`default_nettype none
module ctlog_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ctlog_pkg::CapW-1:0]     cfg_data,
  input  wire logic                           accept,
  input  wire logic                           op,
  input  wire logic [ctlog_pkg::AddrW-1:0]    back_index,
  output ctlog_pkg::ctlog_req_t               req
);

  localparam int AddrW  = ctlog_pkg::AddrW;
  localparam int CapW   = ctlog_pkg::CapW;
  localparam int CountW = ctlog_pkg::CountW;

  logic [CapW-1:0]   capacity;
  logic [AddrW-1:0]  next_slot;
  logic [AddrW-1:0]  next_slot_next;
  logic [CountW-1:0] total_appended;
  logic [CountW-1:0] total_appended_next;

  logic [CapW-1:0]   cap_eff;
  logic [CapW-1:0]   held_now;
  logic [CapW-1:0]   held_after;
  logic [CapW-1:0]   slot_inc;
  logic [CapW:0]     idx_raw;
  logic [CapW:0]     idx_wrap;
  logic              do_append;

  always_comb begin
    cap_eff  = (capacity > ctlog_pkg::CapReset) ? ctlog_pkg::CapReset : capacity;
    held_now = (total_appended < CountW'(cap_eff)) ? total_appended[CapW-1:0] : cap_eff;
    slot_inc = CapW'(next_slot) + CapW'(1);
    // newest is next_slot - 1; wrap once since back < held <= cap
    idx_raw  = (CapW+1)'(next_slot) + (CapW+1)'(cap_eff) - (CapW+1)'(1)
               - (CapW+1)'(back_index);
    idx_wrap = (idx_raw >= (CapW+1)'(cap_eff)) ? idx_raw - (CapW+1)'(cap_eff) : idx_raw;

    req           = '0;
    do_append     = 1'b0;
    next_slot_next      = next_slot;
    total_appended_next = total_appended;
    req.mem_addr  = next_slot;
    if (cap_eff == '0) begin
      req.status = ctlog_pkg::StUnsupported;
    end else if (CapW'(next_slot) >= cap_eff) begin
      req.status = ctlog_pkg::StIntegrity;
    end else if (op == ctlog_pkg::OpAppend) begin
      req.status     = ctlog_pkg::StOk;
      do_append      = 1'b1;
      next_slot_next = (slot_inc >= cap_eff) ? '0 : slot_inc[AddrW-1:0];
      total_appended_next = (total_appended == '1) ? total_appended
                                                   : total_appended + CountW'(1);
    end else if (CapW'(back_index) >= held_now) begin
      req.status = ctlog_pkg::StNotFound;
    end else begin
      req.status   = ctlog_pkg::StOk;
      req.read_ok  = 1'b1;
      req.mem_addr = idx_wrap[AddrW-1:0];
    end

    held_after = (total_appended_next < CountW'(cap_eff))
                 ? total_appended_next[CapW-1:0] : cap_eff;
    req.mem_we         = accept & do_append;
    req.mem_re         = accept & req.read_ok;
    req.write_position = next_slot_next;
    req.held_count     = held_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= ctlog_pkg::CapReset;
      next_slot      <= '0;
      total_appended <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        next_slot      <= next_slot_next;
        total_appended <= total_appended_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/circular_trace_log_unit.sv @@
// Top level of the circular trace log: handshakes, result staging, memory and control.
//
// Input channel (in_valid / in_stall) carries op, record_data and back_index.
// op 0 appends record_data at the write position; op 1 reads the back_index-th
// newest record. Output channel (out_valid / out_stall) returns one result per
// transaction: status, read_data, write_position and held_count after the op.
// Config channel (cfg_valid / cfg_ready) writes the 9-bit capacity; cfg_ready is
// always high. Write it only while the block is idle.
// Path to out_valid: the memory read and the request stage register when an input is
// accepted, and the output register loads when that stage advances.
// Throughput: one transaction per cycle while the output is not stalled; the
// memory takes one access, a write or a read, per transaction.
// Reset (rst, synchronous) empties the pipeline, zeroes the write position and
// count, and sets capacity to 256. Record contents are not cleared.
// While out_stall is high the result holds; one more transaction may sit in the
// memory stage, after which in_stall rises until the output drains.
`default_nettype none
module circular_trace_log_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [8:0]   cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         op,
  input  wire logic [63:0]  record_data,
  input  wire logic [7:0]   back_index,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        status,
  output logic [63:0]       read_data,
  output logic [7:0]        write_position,
  output logic [8:0]        held_count
);

  ctlog_pkg::ctlog_req_t        req;
  ctlog_pkg::ctlog_req_t        s1_req;
  logic                         s1_valid;
  logic                         accept;
  logic                         s1_adv;
  logic [ctlog_pkg::RecW-1:0]   mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid & out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign s1_adv    = s1_valid & (~out_valid | ~out_stall);

  ctlog_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .op         (op),
    .back_index (back_index),
    .req        (req)
  );

  ctlog_ram u_ram (
    .clk     (clk),
    .wr_en   (req.mem_we),
    .wr_addr (req.mem_addr),
    .wr_data (record_data),
    .rd_en   (req.mem_re),
    .rd_addr (req.mem_addr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
    if (s1_adv) begin
      status         <= s1_req.status;
      read_data      <= s1_req.read_ok ? mem_rdata : '0;
      write_position <= s1_req.write_position;
      held_count     <= s1_req.held_count;
    end
  end

endmodule
`default_nettype wire
